// File: design/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// Depends on nothing; used by isort_cell and insertion_sorter_core.
`default_nettype none

package isort_pkg;

  // Default number of values one set may hold
  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned VALUE_W = 32;

  // One input transfer
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_res;
    logic                      overflow;
  } out_item_t;

  // Per-cell control from the core
  typedef struct packed {
    logic ins_en;     // insert the broadcast value this cycle
    logic shift_out;  // move every held value one cell toward cell 0
    logic occupied;   // this cell holds a value of the current set
    logic at_end;     // this cell is the first free one
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on isort_pkg for the value width and the control struct.
`default_nettype none

module isort_cell (
  input  wire logic                                clk_i,
  input  wire isort_pkg::cell_ctrl_t               ctrl_i,
  input  wire logic signed [isort_pkg::VALUE_W-1:0] ins_value_i,
  input  wire logic signed [isort_pkg::VALUE_W-1:0] left_value_i,
  input  wire logic                                left_greater_i,
  input  wire logic signed [isort_pkg::VALUE_W-1:0] right_value_i,
  output      logic signed [isort_pkg::VALUE_W-1:0] value_o,
  output      logic                                greater_o
);
  import isort_pkg::*;

  logic signed [VALUE_W-1:0] val_q, val_d;
  logic                      greater;

  // Held value sorts after the incoming one; equal values keep arrival order
  assign greater = ctrl_i.occupied && (val_q > ins_value_i);

  // Pick the next held value: drain, shift right on insert, take new, or hold
  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift_out) begin
      val_d = right_value_i;
    end else if (ctrl_i.ins_en) begin
      if (left_greater_i) begin
        val_d = left_value_i;
      end else if (greater || ctrl_i.at_end) begin
        val_d = ins_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o   = val_q;
  assign greater_o = greater;

endmodule

`default_nettype wire

// File: design/insertion_sorter_core.sv
// Insertion sorter top level: a chain of compare-and-shift cells plus fill and drain control.
// Depends on isort_pkg and isort_cell.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) carries one signed value per
//    transfer; the last flag closes the set. Each accepted value is placed in the chain
//    as it is registered, so a set streams in at one value per cycle while input is not stalled.
//  - Values arriving while CAPACITY are already held are dropped; every result of that
//    set then has overflow set.
//  - After the marked transfer the chain drains through cell 0 into an output register,
//    one result per cycle while the receiver does not stall, in ascending order, the
//    final one with last_res set. Input is stalled while the drain runs.
//  - First result becomes valid after the marked transfer sets the drain flag and the
//    drain then loads the output register.
//  - A receiver stall on out_stall_i holds the output register and pauses the drain;
//    nothing is lost. The next set may start while the final result still waits.
//  - Reset empties the chain and clears the overflow flag; cell contents are not
//    cleared, only the fill count says which cells hold data.
`default_nettype none

module insertion_sorter_core #(
  parameter int unsigned CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire isort_pkg::in_item_t  in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      isort_pkg::out_item_t out_data_o
);
  import isort_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drain_q, drain_d;
  logic             dropped_q, dropped_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q;

  logic             in_xfer;
  logic             full;
  logic             ld;
  logic             last_one;

  cell_ctrl_t                ctrl  [CAPACITY];
  logic signed [VALUE_W-1:0] vals  [CAPACITY];
  logic                      grt   [CAPACITY];

  assign in_stall_o = drain_q;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign ld         = drain_q && (!out_valid_q || !out_stall_i);
  assign last_one   = (cnt_q == CNT_W'(1));

  // Build the cell chain
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val, right_val;
    logic                      left_grt;

    assign ctrl[k].ins_en    = in_xfer && !full;
    assign ctrl[k].shift_out = ld;
    assign ctrl[k].occupied  = (cnt_q > CNT_W'(k));
    assign ctrl[k].at_end    = (cnt_q == CNT_W'(k));

    if (k == 0) begin : g_first
      assign left_val = '0;
      assign left_grt = 1'b0;
    end else begin : g_inner
      assign left_val = vals[k-1];
      assign left_grt = grt[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_body
      assign right_val = vals[k+1];
    end

    isort_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl[k]),
      .ins_value_i    (in_data_i.value),
      .left_value_i   (left_val),
      .left_greater_i (left_grt),
      .right_value_i  (right_val),
      .value_o        (vals[k]),
      .greater_o      (grt[k])
    );
  end

  // Track fill count, overflow and drain phase
  always_comb begin
    cnt_d     = cnt_q;
    drain_d   = drain_q;
    dropped_d = dropped_q;
    if (in_xfer) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (in_data_i.last) begin
        drain_d = 1'b1;
      end
    end else if (ld) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (last_one) begin
        drain_d   = 1'b0;
        dropped_d = 1'b0;
      end
    end
  end

  // Output register: load on drain, drop the valid once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drain_q     <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      drain_q     <= drain_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_data_q.sorted_value <= vals[0];
      out_data_q.last_res     <= last_one;
      out_data_q.overflow     <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Fill count never passes the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // A drain always has something left to emit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> cnt_q != '0)
    else $error("drain with empty chain");

  // Emitting the final result empties the chain and ends the drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld && last_one |=> cnt_q == '0 && !drain_q && !dropped_q)
    else $error("chain not cleared after final result");

  // A marked transfer starts the drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.last |=> drain_q)
    else $error("marked transfer did not start drain");

  // Overflow is raised only by a transfer that met a full chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dropped_q) |-> $past(cnt_q) == CNT_W'(CAPACITY) && $past(in_xfer))
    else $error("overflow raised without full chain");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for insertion_sorter_core: streams signed value sets through the sorter and
// checks each sorted result against an in-bench predictor. Depends on isort_pkg and the RTL.

module tb_top;
  import isort_pkg::*;

  localparam int CAP            = int'(CAPACITY_DEF);
  localparam int ITEMS_TOTAL    = 330;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int DRAIN_SETTLE   = 4;
  localparam int END_SETTLE     = 10;
  localparam int STALL_LIMIT    = 1000;
  localparam int PRINT_LIMIT    = 40;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {PICK_ANY, PICK_NARROW, PICK_EDGES} pick_mode_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predictor state
  logic signed [VALUE_W-1:0] held_vals[$];
  bit                        set_dropped;
  out_item_t                 pending_sorted[$];
  out_item_t                 want;

  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit rx_hold_req = 1'b0;

  int errors = 0;
  int items_sent = 0;
  int sets_closed = 0;
  int overflow_sets = 0;
  int results_checked = 0;
  int quiet_cycles = 0;

  insertion_sorter_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (errors < PRINT_LIMIT) begin
      $display("ERROR %0t: %s", $time, what);
    end
    errors++;
  endtask

  // Insert one accepted value in order, or mark the set dropped when full; on a marked transfer, queue the sorted set.
  task automatic predict_sorted(input in_item_t item);
    int pos;
    out_item_t res;
    if (held_vals.size() >= CAP) begin
      set_dropped = 1'b1;
    end else begin
      pos = held_vals.size();
      for (int k = 0; k < held_vals.size(); k++) begin
        if (held_vals[k] > $signed(item.value)) begin
          pos = k;
          break;
        end
      end
      held_vals.insert(pos, item.value);
    end
    if (item.last) begin
      foreach (held_vals[k]) begin
        res.sorted_value = held_vals[k];
        res.last_res     = (k == held_vals.size() - 1);
        res.overflow     = set_dropped;
        pending_sorted.push_back(res);
      end
      sets_closed++;
      if (set_dropped) overflow_sets++;
      held_vals.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Offer one value, idling at random first; hold the payload until the transfer.
  task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic is_last);
    in_item_t item;
    item.value = v;
    item.last  = is_last;
    while (tx_gaps_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_sorted(item);
    items_sent++;
  endtask

  // Pause the sender until every queued result has been taken.
  task automatic wait_drained;
    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(input pick_mode_e mode);
    case (mode)
      PICK_NARROW: return int'($urandom_range(16)) - 8;
      PICK_EDGES: begin
        case ($urandom_range(3))
          0:       return VAL_MIN + int'($urandom_range(2));
          1:       return VAL_MAX - int'($urandom_range(2));
          2:       return int'($urandom_range(2)) - 1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(input int n, input pick_mode_e mode);
    for (int k = 0; k < n; k++) begin
      send_value(pick_value(mode), k == n - 1);
    end
  endtask

  task automatic test_single_min;
    send_value(VAL_MIN, 1'b1);
    wait_drained();
  endtask

  task automatic test_extremes;
    send_value(VAL_MAX, 1'b0);
    send_value(0, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(-1, 1'b0);
    send_value(1, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX - 1, 1'b0);
    send_value(VAL_MIN + 1, 1'b1);
    wait_drained();
  endtask

  // Each value lands at the front, then each lands at the back.
  task automatic test_ordered_runs;
    for (int k = 5; k >= 0; k--) send_value(k, k == 0);
    for (int k = -2; k <= 1; k++) send_value(k, k == 1);
    wait_drained();
  endtask

  // Stream a set that exactly fills the store, one transfer per cycle.
  task automatic test_full_set;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_set(CAP, PICK_ANY);
    wait_drained();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Overrun the store by two, so an unmarked and the marked value are dropped.
  task automatic test_overflow;
    send_set(CAP + 2, PICK_EDGES);
    wait_drained();
  endtask

  // Hold the receiver off while a set arrives; two more sets wait behind it.
  task automatic test_backpressure;
    tx_gaps_on  = 1'b0;
    rx_hold_req = 1'b1;
    send_set(12, PICK_ANY);
    send_set(8, PICK_NARROW);
    send_set(3, PICK_ANY);
    tx_gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_sets;
    int n;
    pick_mode_e mode;
    while (items_sent < ITEMS_TOTAL) begin
      n    = ($urandom_range(11) == 0) ? int'($urandom_range(40, 70))
                                      : int'($urandom_range(1, 10));
      mode = pick_mode_e'($urandom_range(2));
      send_set(n, mode);
      if ($urandom_range(3) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= rx_gaps_on && ($urandom_range(99) < 25);
      end
    end
  end

  // Compare each result transfer with the oldest pending prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", $signed(out_data.sorted_value)));
      end else begin
        want = pending_sorted.pop_front();
        if (out_data.sorted_value !== want.sorted_value)
          report_mismatch($sformatf("sorted_value %0d, want %0d",
                                    $signed(out_data.sorted_value),
                                    $signed(want.sorted_value)));
        if (out_data.last_res !== want.last_res)
          report_mismatch($sformatf("last_res %b, want %b", out_data.last_res,
                                    want.last_res));
        if (out_data.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b", out_data.overflow,
                                    want.overflow));
      end
      results_checked++;
    end
  end

  // End the run if no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_single_min();
    test_extremes();
    test_ordered_runs();
    test_full_set();
    test_overflow();
    test_backpressure();
    test_random_sets();
    if (pending_sorted.size() != 0) report_mismatch("results still pending at end");
    repeat (END_SETTLE) @(posedge clk);
    $display("Sent %0d values in %0d sets (%0d with dropped values), checked %0d results.",
             items_sent, sets_closed, overflow_sets, results_checked);
    $display("Included a full-capacity burst and a long receiver hold-off.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
